@@ sv/fat_chain_table_engine_assert.svh @@
// Assertion macros for the chain table engine RTL, included by the sequencer.
`ifndef FAT_CHAIN_TABLE_ENGINE_ASSERT_SVH
`define FAT_CHAIN_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define FCTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define FCTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/fcte_pkg.sv @@
// Package: constants, codes and shared types of the chain table engine.
`default_nettype none

package fcte_pkg;

	localparam int unsigned ENTRIES = 4096;
	localparam int unsigned ADDR_W  = $clog2(ENTRIES);
	localparam int unsigned CNT_W   = ADDR_W + 1;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned LINK_W  = 28;

	localparam logic [LINK_W-1:0] END_LOW  = 28'hFFFFFF8;
	localparam logic [WORD_W-1:0] END_MARK = 32'h0FFFFFFF;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_COUNT = 2'd2;
	localparam logic [1:0] OP_ALLOC = 2'd3;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_ZERO  = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_RANGE = 3'd3;
	localparam logic [2:0] ST_LIMIT = 3'd4;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              is_end;
		logic [2:0]        status;
	} res_t;

endpackage

`default_nettype wire

@@ sv/fcte_link_ram.sv @@
// Link table storage: one write port, one registered read port.
`default_nettype none

module fcte_link_ram
	import fcte_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_req_t          req,
	output logic [WORD_W-1:0]      rd_data
);

	logic [WORD_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/fcte_ctrl.sv @@
// Operation sequencer: decodes a word, writes or reads an entry, walks or scans the table, builds the result.
`default_nettype none

module fcte_ctrl
	import fcte_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        opcode,
	input  wire logic [11:0]       index,
	input  wire logic [WORD_W-1:0] value,
	output mem_req_t               req,
	input  wire logic [WORD_W-1:0] rd_data,
	output res_t                   res,
	output logic                   res_valid,
	input  wire logic              slot_free
);

	`include "fat_chain_table_engine_assert.svh"

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_COUNT = 3'd2;
	localparam logic [2:0] S_ALLOC = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] scan_q;
	res_t              res_q;

	logic [LINK_W-1:0] link;
	logic              link_free;
	logic              link_end;
	logic              link_oor;
	logic              cnt_lim;
	logic              scan_last;
	logic              idx_ok;
	logic [ADDR_W-1:0] idx_addr;
	logic              accept;

	assign link      = rd_data[LINK_W-1:0];
	assign link_free = (link == '0);
	assign link_end  = (link >= END_LOW);
	assign link_oor  = (WORD_W'(link) >= WORD_W'(ENTRIES));
	assign cnt_lim   = (cnt_q >= CNT_W'(ENTRIES));
	assign scan_last = (scan_q == ADDR_W'(ENTRIES - 1));
	assign idx_ok    = (WORD_W'(index) < WORD_W'(ENTRIES));
	assign idx_addr  = ADDR_W'(index);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign res_valid = (state_q == S_EMIT);
	assign res       = res_q;

	// table port requests
	always_comb begin
		req = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (opcode)
						OP_WRITE: begin
							req.wr_en   = idx_ok;
							req.wr_addr = idx_addr;
							req.wr_data = value;
						end
						OP_READ, OP_COUNT: begin
							req.rd_en   = idx_ok;
							req.rd_addr = idx_addr;
						end
						OP_ALLOC: begin
							req.rd_en   = 1'b1;
							req.rd_addr = '0;
						end
						default: ;
					endcase
				end
			end
			S_COUNT: begin
				req.rd_en   = !link_free && !link_end && !link_oor && !cnt_lim;
				req.rd_addr = ADDR_W'(link);
			end
			S_ALLOC: begin
				if (link_free) begin
					req.wr_en   = 1'b1;
					req.wr_addr = scan_q;
					req.wr_data = END_MARK;
				end else begin
					req.rd_en   = !scan_last;
					req.rd_addr = scan_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			scan_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q  <= CNT_W'(1);
						scan_q <= '0;
						if (!idx_ok && opcode != OP_ALLOC) begin
							state_q <= S_EMIT;
						end else begin
							case (opcode)
								OP_READ:  state_q <= S_READ;
								OP_COUNT: state_q <= S_COUNT;
								OP_ALLOC: state_q <= S_ALLOC;
								default:  state_q <= S_EMIT;
							endcase
						end
					end
				end
				S_READ: state_q <= S_EMIT;
				S_COUNT: begin
					if (link_free || link_end || link_oor || cnt_lim) begin
						state_q <= S_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ALLOC: begin
					if (link_free || scan_last) begin
						state_q <= S_EMIT;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word, built in the cycle that ends the operation
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_q.value  <= '0;
				res_q.is_end <= 1'b0;
				res_q.status <= (idx_ok || opcode == OP_ALLOC) ? ST_OK : ST_RANGE;
			end
			S_READ: begin
				res_q.value  <= rd_data;
				res_q.is_end <= link_end;
				res_q.status <= ST_OK;
			end
			S_COUNT: begin
				res_q.value  <= link_end ? WORD_W'(cnt_q) : '0;
				res_q.is_end <= 1'b0;
				if (link_free) begin
					res_q.status <= ST_ZERO;
				end else if (link_end) begin
					res_q.status <= ST_OK;
				end else if (link_oor) begin
					res_q.status <= ST_RANGE;
				end else begin
					res_q.status <= ST_LIMIT;
				end
			end
			S_ALLOC: begin
				res_q.is_end <= 1'b0;
				if (link_free) begin
					res_q.value  <= WORD_W'(scan_q);
					res_q.status <= ST_OK;
				end else begin
					res_q.value  <= '0;
					res_q.status <= ST_FULL;
				end
			end
			default: ;
		endcase
	end

	`FCTE_ASSERT_NEXT(a_emit_hold, res_valid && !slot_free, res_valid && $stable(res_q), "result word changed while waiting for the output slot")
	`FCTE_ASSERT_NOW(a_write_phase, req.wr_en, state_q == S_IDLE || state_q == S_ALLOC, "table written outside a write or allocate step")
	`FCTE_ASSERT_NOW(a_walk_count, state_q == S_COUNT, cnt_q != '0 && cnt_q <= CNT_W'(ENTRIES), "chain walk count out of bounds")
	`FCTE_ASSERT_NEXT(a_read_follows, accept && opcode == OP_READ && idx_ok, state_q == S_READ, "read word did not wait for table data")

endmodule

`default_nettype wire

@@ sv/fat_chain_table_engine.sv @@
// Top level: FAT32 link table engine with sequencer, table memory and output register.
`default_nettype none

// FAT32 link table of ENTRIES 32-bit words (4096 here) in one single-port-read
// synchronous memory. Opcodes: write, read, count chain, allocate lowest free
// entry. One operation is in flight at a time; the next word is taken while the
// previous result still waits in the output register. Write and read each make
// one table access; count follows a chain cluster by cluster, and allocate
// scans entries from 0 upward, up to ENTRIES of them. Count and allocate are
// paced by the memory read port, one table entry per cycle. Only the low 28
// bits of a link take part in link tests.
module fat_chain_table_engine
	import fcte_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        opcode,
	input  wire logic [11:0]       index,
	input  wire logic [WORD_W-1:0] value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WORD_W-1:0]      result_value,
	output logic                   is_end,
	output logic [2:0]             status
);

	mem_req_t          req;
	logic [WORD_W-1:0] rd_data;
	res_t              res;
	logic              res_valid;
	logic              slot_free;
	logic              out_valid_q;
	res_t              out_q;

	fcte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.index    (index),
		.value    (value),
		.req      (req),
		.rd_data  (rd_data),
		.res      (res),
		.res_valid(res_valid),
		.slot_free(slot_free)
	);

	fcte_link_ram u_ram (
		.clk    (clk),
		.req    (req),
		.rd_data(rd_data)
	);

	// output register: free when empty or being taken this cycle
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && slot_free) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_q.value;
	assign is_end       = out_q.is_end;
	assign status       = out_q.status;

endmodule

`default_nettype wire
